// ----- rtl/trrs_pkg.sv -----
`default_nettype none
package trrs_pkg;

    // table geometry
    localparam int MAX_TASKS   = 256;
    localparam int ID_W        = 16;
    localparam int SLOT_W      = $clog2(MAX_TASKS);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int VISIT_W     = SLOT_W + 2;
    localparam int VISIT_LIMIT = 2 * MAX_TASKS;
    localparam int MODE_W      = 3;
    localparam int ST_W        = 2;

    // request codes
    localparam logic [MODE_W-1:0] MODE_ADD_NEW = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD_ID  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FORK    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EXIT    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WAIT    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SCHED   = 3'd5;

    // task status codes
    localparam logic [ST_W-1:0] TS_FINISHED = 2'd0;
    localparam logic [ST_W-1:0] TS_READY    = 2'd1;
    localparam logic [ST_W-1:0] TS_WAITING  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FORK,
        ST_WCHK,
        ST_WSRCH,
        ST_SRD,
        ST_SEXAM,
        ST_SSRCH
    } ctrl_state_t;

    // datapath micro-operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RD_CUR,
        OP_ADD,
        OP_EXIT,
        OP_WAIT_SET,
        OP_SRCH_ARG,
        OP_SRCH_WAIT,
        OP_SRCH,
        OP_SCHED_INIT,
        OP_RD_POS,
        OP_PICK,
        OP_ADVANCE,
        OP_FREE,
        OP_JUMP,
        OP_FAIL
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              empty;
        logic              cur_valid;
        logic              arg_zero;
        logic              arg_is_cur;
        logic              visits_done;
        logic [ST_W-1:0]   rd_st;
        logic              rd_wait_nz;
        logic              hit;
        logic              miss;
    } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/trrs_ctrl.sv -----
`default_nettype none
module trrs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire trrs_pkg::dp_stat_t stat,
    output trrs_pkg::dp_cmd_t      cmd
);

    trrs_pkg::ctrl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= trrs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            trrs_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = trrs_pkg::ST_DECODE;
                end
            end
            trrs_pkg::ST_DECODE:
            begin
                state_next = trrs_pkg::ST_IDLE;
                if (stat.mode == trrs_pkg::MODE_FORK && stat.cur_valid && !stat.full)
                begin
                    state_next = trrs_pkg::ST_FORK;
                end
                else if (stat.mode == trrs_pkg::MODE_WAIT && stat.cur_valid
                         && !stat.arg_zero)
                begin
                    state_next = trrs_pkg::ST_WCHK;
                end
                else if (stat.mode == trrs_pkg::MODE_SCHED && !stat.empty)
                begin
                    state_next = trrs_pkg::ST_SRD;
                end
            end
            trrs_pkg::ST_FORK:
            begin
                state_next = trrs_pkg::ST_IDLE;
            end
            trrs_pkg::ST_WCHK:
            begin
                state_next = stat.arg_is_cur ? trrs_pkg::ST_IDLE : trrs_pkg::ST_WSRCH;
            end
            trrs_pkg::ST_WSRCH:
            begin
                if (stat.hit || stat.miss)
                begin
                    state_next = trrs_pkg::ST_IDLE;
                end
            end
            trrs_pkg::ST_SRD:
            begin
                state_next = stat.visits_done ? trrs_pkg::ST_IDLE : trrs_pkg::ST_SEXAM;
            end
            trrs_pkg::ST_SEXAM:
            begin
                if (stat.rd_st == trrs_pkg::TS_READY)
                begin
                    state_next = trrs_pkg::ST_IDLE;
                end
                else if (stat.rd_st == trrs_pkg::TS_WAITING && stat.rd_wait_nz)
                begin
                    state_next = trrs_pkg::ST_SSRCH;
                end
                else
                begin
                    state_next = trrs_pkg::ST_SRD;
                end
            end
            trrs_pkg::ST_SSRCH:
            begin
                if (stat.hit || stat.miss)
                begin
                    state_next = trrs_pkg::ST_SRD;
                end
            end
            default:
            begin
                state_next = trrs_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd.op = trrs_pkg::OP_NONE;
        unique case (state_reg)
            trrs_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op = trrs_pkg::OP_LOAD;
                end
            end
            trrs_pkg::ST_DECODE:
            begin
                cmd.op = trrs_pkg::OP_FAIL;
                if ((stat.mode == trrs_pkg::MODE_ADD_NEW
                     || stat.mode == trrs_pkg::MODE_ADD_ID) && !stat.full)
                begin
                    cmd.op = trrs_pkg::OP_ADD;
                end
                else if (stat.mode == trrs_pkg::MODE_FORK && stat.cur_valid
                         && !stat.full)
                begin
                    cmd.op = trrs_pkg::OP_RD_CUR;
                end
                else if (stat.mode == trrs_pkg::MODE_EXIT && stat.cur_valid)
                begin
                    cmd.op = trrs_pkg::OP_EXIT;
                end
                else if (stat.mode == trrs_pkg::MODE_WAIT && stat.cur_valid
                         && !stat.arg_zero)
                begin
                    cmd.op = trrs_pkg::OP_RD_CUR;
                end
                else if (stat.mode == trrs_pkg::MODE_SCHED && !stat.empty)
                begin
                    cmd.op = trrs_pkg::OP_SCHED_INIT;
                end
            end
            trrs_pkg::ST_FORK:
            begin
                cmd.op = trrs_pkg::OP_ADD;
            end
            trrs_pkg::ST_WCHK:
            begin
                cmd.op = stat.arg_is_cur ? trrs_pkg::OP_FAIL : trrs_pkg::OP_SRCH_ARG;
            end
            trrs_pkg::ST_WSRCH:
            begin
                if (stat.hit)
                begin
                    cmd.op = (stat.rd_st != trrs_pkg::TS_FINISHED)
                             ? trrs_pkg::OP_WAIT_SET : trrs_pkg::OP_FAIL;
                end
                else if (stat.miss)
                begin
                    cmd.op = trrs_pkg::OP_FAIL;
                end
                else
                begin
                    cmd.op = trrs_pkg::OP_SRCH;
                end
            end
            trrs_pkg::ST_SRD:
            begin
                cmd.op = stat.visits_done ? trrs_pkg::OP_FAIL : trrs_pkg::OP_RD_POS;
            end
            trrs_pkg::ST_SEXAM:
            begin
                if (stat.rd_st == trrs_pkg::TS_READY)
                begin
                    cmd.op = trrs_pkg::OP_PICK;
                end
                else if (stat.rd_st == trrs_pkg::TS_WAITING && stat.rd_wait_nz)
                begin
                    cmd.op = trrs_pkg::OP_SRCH_WAIT;
                end
                else
                begin
                    cmd.op = trrs_pkg::OP_ADVANCE;
                end
            end
            trrs_pkg::ST_SSRCH:
            begin
                if (stat.hit && stat.rd_st == trrs_pkg::TS_FINISHED)
                begin
                    cmd.op = trrs_pkg::OP_FREE;
                end
                else if (stat.hit && stat.rd_st == trrs_pkg::TS_READY)
                begin
                    cmd.op = trrs_pkg::OP_JUMP;
                end
                else if (stat.hit || stat.miss)
                begin
                    cmd.op = trrs_pkg::OP_ADVANCE;
                end
                else
                begin
                    cmd.op = trrs_pkg::OP_SRCH;
                end
            end
            default:
            begin
                cmd.op = trrs_pkg::OP_NONE;
            end
        endcase
    end

    assign busy = (state_reg != trrs_pkg::ST_IDLE);

    // checks
    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == trrs_pkg::OP_LOAD) |-> (state_reg == trrs_pkg::ST_IDLE))
        else $error("request loaded while busy");
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == trrs_pkg::ST_DECODE))
        else $error("accepted request not decoded");
    a_exam_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == trrs_pkg::ST_SEXAM) |-> ($past(cmd.op) == trrs_pkg::OP_RD_POS))
        else $error("slot examined without a read");

endmodule
`default_nettype wire

// ----- rtl/trrs_datapath.sv -----
`default_nettype none
module trrs_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [trrs_pkg::MODE_W-1:0]   mode,
    input  wire logic [trrs_pkg::ID_W-1:0]     pid_arg,
    input  wire trrs_pkg::dp_cmd_t             cmd,
    output trrs_pkg::dp_stat_t                 stat,
    output logic                               done,
    output logic                               ok,
    output logic [trrs_pkg::ID_W-1:0]          pid_out,
    output logic [trrs_pkg::SLOT_W-1:0]        slot_out
);

    localparam int SW = trrs_pkg::SLOT_W;
    localparam int CW = trrs_pkg::CNT_W;
    localparam int IW = trrs_pkg::ID_W;
    localparam int VW = trrs_pkg::VISIT_W;
    localparam int TW = trrs_pkg::ST_W;

    // task table
    logic [IW-1:0] mem_id     [trrs_pkg::MAX_TASKS];
    logic [IW-1:0] mem_parent [trrs_pkg::MAX_TASKS];
    logic [TW-1:0] mem_status [trrs_pkg::MAX_TASKS];
    logic [IW-1:0] mem_wait   [trrs_pkg::MAX_TASKS];

    logic [CW-1:0]                count_reg;
    logic [SW-1:0]                cur_reg;
    logic                         cur_valid_reg;
    logic [IW-1:0]                next_id_reg;
    logic [SW-1:0]                pos_reg;
    logic [VW-1:0]                visits_reg;
    logic [CW-1:0]                idx_reg;
    logic                         srch_v_reg;
    logic [IW-1:0]                tgt_reg;
    logic [trrs_pkg::MODE_W-1:0]  mode_reg;
    logic [IW-1:0]                arg_reg;
    logic [IW-1:0]                rd_id_reg;
    logic [TW-1:0]                rd_st_reg;
    logic [IW-1:0]                rd_wait_reg;
    logic [SW-1:0]                rd_slot_reg;
    logic                         done_reg;
    logic                         ok_reg;
    logic [IW-1:0]                pid_reg;
    logic [SW-1:0]                slot_reg;

    logic [SW-1:0] rd_addr;
    logic [SW-1:0] pos_adv;
    logic [SW-1:0] cur_adv;
    logic          wr_add;
    logic          wr_st;
    logic          wr_wait;
    logic [SW-1:0] wr_addr;
    logic [TW-1:0] wr_st_val;
    logic [IW-1:0] wr_wait_val;
    logic [IW-1:0] add_id;
    logic [IW-1:0] add_parent;
    logic          hit;
    logic          miss;

    // wrap-around successors within the occupied part of the table
    assign pos_adv = ((CW'(pos_reg) + CW'(1)) == count_reg) ? '0 : pos_reg + SW'(1);
    assign cur_adv = ((CW'(cur_reg) + CW'(1)) == count_reg) ? '0 : cur_reg + SW'(1);

    assign hit  = srch_v_reg && (rd_id_reg == tgt_reg);
    assign miss = !srch_v_reg && (idx_reg >= count_reg);

    // read address select
    always_comb
    begin
        unique case (cmd.op)
            trrs_pkg::OP_RD_CUR: rd_addr = cur_reg;
            trrs_pkg::OP_SRCH:   rd_addr = idx_reg[SW-1:0];
            default:             rd_addr = pos_reg;
        endcase
    end

    // write controls
    always_comb
    begin
        wr_add      = (cmd.op == trrs_pkg::OP_ADD);
        wr_st       = 1'b0;
        wr_wait     = 1'b0;
        wr_addr     = cur_reg;
        wr_st_val   = trrs_pkg::TS_FINISHED;
        wr_wait_val = '0;
        add_id      = (mode_reg == trrs_pkg::MODE_ADD_ID) ? arg_reg : next_id_reg;
        add_parent  = (mode_reg == trrs_pkg::MODE_FORK) ? rd_id_reg : '0;
        unique case (cmd.op)
            trrs_pkg::OP_EXIT:
            begin
                wr_st = 1'b1;
            end
            trrs_pkg::OP_WAIT_SET:
            begin
                wr_st       = 1'b1;
                wr_wait     = 1'b1;
                wr_st_val   = trrs_pkg::TS_WAITING;
                wr_wait_val = arg_reg;
            end
            trrs_pkg::OP_FREE:
            begin
                wr_st     = 1'b1;
                wr_wait   = 1'b1;
                wr_addr   = pos_reg;
                wr_st_val = trrs_pkg::TS_READY;
            end
            trrs_pkg::OP_ADD:
            begin
                wr_st     = 1'b1;
                wr_wait   = 1'b1;
                wr_addr   = count_reg[SW-1:0];
                wr_st_val = trrs_pkg::TS_READY;
            end
            default:
            begin
                wr_st = 1'b0;
            end
        endcase
    end

    // table memories, registered read
    always_ff @(posedge clk)
    begin
        if (wr_add)
        begin
            mem_id[wr_addr]     <= add_id;
            mem_parent[wr_addr] <= add_parent;
        end
        if (wr_st)
        begin
            mem_status[wr_addr] <= wr_st_val;
        end
        if (wr_wait)
        begin
            mem_wait[wr_addr] <= wr_wait_val;
        end
        rd_id_reg   <= mem_id[rd_addr];
        rd_st_reg   <= mem_status[rd_addr];
        rd_wait_reg <= mem_wait[rd_addr];
        rd_slot_reg <= rd_addr;
    end

    // request latch and search target
    always_ff @(posedge clk)
    begin
        if (cmd.op == trrs_pkg::OP_LOAD)
        begin
            mode_reg <= mode;
            arg_reg  <= pid_arg;
        end
        if (cmd.op == trrs_pkg::OP_SRCH_ARG)
        begin
            tgt_reg <= arg_reg;
        end
        else if (cmd.op == trrs_pkg::OP_SRCH_WAIT)
        begin
            tgt_reg <= rd_wait_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            next_id_reg   <= IW'(1);
            pos_reg       <= '0;
            visits_reg    <= '0;
            idx_reg       <= '0;
            srch_v_reg    <= 1'b0;
            done_reg      <= 1'b0;
            ok_reg        <= 1'b0;
            pid_reg       <= '0;
            slot_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (cmd.op)
                trrs_pkg::OP_ADD:
                begin
                    count_reg <= count_reg + CW'(1);
                    if (mode_reg != trrs_pkg::MODE_ADD_ID)
                    begin
                        next_id_reg <= next_id_reg + IW'(1);
                    end
                    done_reg <= 1'b1;
                    ok_reg   <= 1'b1;
                    pid_reg  <= add_id;
                    slot_reg <= count_reg[SW-1:0];
                end
                trrs_pkg::OP_EXIT, trrs_pkg::OP_WAIT_SET:
                begin
                    done_reg <= 1'b1;
                    ok_reg   <= 1'b1;
                    pid_reg  <= '0;
                    slot_reg <= '0;
                end
                trrs_pkg::OP_FAIL:
                begin
                    done_reg <= 1'b1;
                    ok_reg   <= 1'b0;
                    pid_reg  <= '0;
                    slot_reg <= '0;
                end
                trrs_pkg::OP_PICK:
                begin
                    cur_reg       <= pos_reg;
                    cur_valid_reg <= 1'b1;
                    done_reg      <= 1'b1;
                    ok_reg        <= 1'b1;
                    pid_reg       <= rd_id_reg;
                    slot_reg      <= pos_reg;
                end
                trrs_pkg::OP_SCHED_INIT:
                begin
                    pos_reg    <= cur_valid_reg ? cur_adv : '0;
                    visits_reg <= '0;
                end
                trrs_pkg::OP_SRCH_ARG, trrs_pkg::OP_SRCH_WAIT:
                begin
                    idx_reg    <= '0;
                    srch_v_reg <= 1'b0;
                end
                trrs_pkg::OP_SRCH:
                begin
                    idx_reg    <= idx_reg + CW'(1);
                    srch_v_reg <= (idx_reg < count_reg);
                end
                trrs_pkg::OP_ADVANCE, trrs_pkg::OP_FREE:
                begin
                    pos_reg    <= pos_adv;
                    visits_reg <= visits_reg + VW'(1);
                end
                trrs_pkg::OP_JUMP:
                begin
                    pos_reg    <= rd_slot_reg;
                    visits_reg <= visits_reg + VW'(1);
                end
                default:
                begin
                    done_reg <= 1'b0;
                end
            endcase
        end
    end

    // status to controller
    always_comb
    begin
        stat.mode        = mode_reg;
        stat.full        = (count_reg >= CW'(trrs_pkg::MAX_TASKS));
        stat.empty       = (count_reg == '0);
        stat.cur_valid   = cur_valid_reg;
        stat.arg_zero    = (arg_reg == '0);
        stat.arg_is_cur  = (rd_id_reg == arg_reg);
        stat.visits_done = (visits_reg >= VW'(trrs_pkg::VISIT_LIMIT));
        stat.rd_st       = rd_st_reg;
        stat.rd_wait_nz  = (rd_wait_reg != '0);
        stat.hit         = hit;
        stat.miss        = miss;
    end

    assign done     = done_reg;
    assign ok       = ok_reg;
    assign pid_out  = pid_reg;
    assign slot_out = slot_reg;

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(trrs_pkg::MAX_TASKS))
        else $error("task count beyond table size");
    a_cur_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (CW'(cur_reg) < count_reg))
        else $error("current slot outside occupied table");
    a_pos_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (CW'(pos_reg) < count_reg))
        else $error("scan position outside occupied table");
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !ok_reg) |-> (pid_reg == '0 && slot_reg == '0))
        else $error("failed request carries data");

endmodule
`default_nettype wire

// ----- rtl/task_table_round_robin_scheduler.sv -----
`default_nettype none
// Round-robin task table scheduler.
// Request channel: drive mode and pid_arg with start high; the request is
// taken on the rising edge where start is high and busy is low. busy stays
// high until the result is produced.
// Result channel: done pulses for one cycle with ok, pid_out and slot_out.
// The receiver cannot stall; the result is presented exactly once.
// Add, add-with-id, exit and requests refused at decode finish from the decode
// state; fork writes the new task in a further state; a wait reads the current
// task, refuses a wait on its own id, and otherwise searches the table for the
// id one slot at a time until it matches or the occupied slots run out.
// Schedule reads and examines one slot at a time, plus for each waiting slot a
// linear id lookup; the single table read port makes this serial. Worst case
// is bounded by 512 slot visits.
// A new request can be taken in the cycle done is high.
// Reset (rst_n low, asynchronous) empties the table, clears the current
// task and sets the next fresh id to 1. No clearing pass is needed: only
// data from occupied slots is ever used.
module task_table_round_robin_scheduler (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [trrs_pkg::MODE_W-1:0]   mode,
    input  wire logic [trrs_pkg::ID_W-1:0]     pid_arg,
    output logic                               done,
    output logic                               ok,
    output logic [trrs_pkg::ID_W-1:0]          pid_out,
    output logic [trrs_pkg::SLOT_W-1:0]        slot_out
);

    trrs_pkg::dp_cmd_t  cmd;
    trrs_pkg::dp_stat_t stat;

    trrs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    trrs_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode),
        .pid_arg  (pid_arg),
        .cmd      (cmd),
        .stat     (stat),
        .done     (done),
        .ok       (ok),
        .pid_out  (pid_out),
        .slot_out (slot_out)
    );

endmodule
`default_nettype wire

// ----- tb/task_table_round_robin_scheduler_test.sv -----
`timescale 1ns / 1ps
module task_table_round_robin_scheduler_test;
    import trrs_pkg::*;

    // codes outside the defined request set
    localparam logic [MODE_W-1:0] MODE_UNDEF_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNDEF_B = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [MODE_W-1:0]   mode;
    logic [ID_W-1:0]     pid_arg;
    logic                done;
    logic                ok;
    logic [ID_W-1:0]     pid_out;
    logic [SLOT_W-1:0]   slot_out;

    task_table_round_robin_scheduler dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .mode     (mode),
        .pid_arg  (pid_arg),
        .done     (done),
        .ok       (ok),
        .pid_out  (pid_out),
        .slot_out (slot_out)
    );

    typedef struct packed {
        logic              ok;
        logic [ID_W-1:0]   pid;
        logic [SLOT_W-1:0] slot;
    } sched_result_t;

    sched_result_t pending_results[$];

    // shadow task table
    logic [ID_W-1:0] tab_id     [MAX_TASKS];
    logic [ID_W-1:0] tab_parent [MAX_TASKS];
    logic [ID_W-1:0] tab_wait   [MAX_TASKS];
    logic [ST_W-1:0] tab_st     [MAX_TASKS];
    int unsigned     n_tasks;
    int unsigned     cur_slot;
    bit              cur_valid;
    logic [ID_W-1:0] fresh_id;

    int unsigned errors;
    int unsigned n_requests;
    int unsigned n_checked;
    int unsigned n_picked;
    int unsigned n_refused;
    bit          no_idle;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // a schedule may scan 512 slots with a full lookup each: allow for that
    initial
    begin
        #2_000_000_000;
        $display("timeout at %0t", $time);
        $display("== FAIL ==");
        $finish;
    end

    // first occupied slot holding this id, -1 if none
    function automatic int find_task(input logic [ID_W-1:0] id);
        for (int i = 0; i < int'(n_tasks); i++)
        begin
            if (tab_id[i] == id)
                return i;
        end
        return -1;
    endfunction

    function automatic bit append_task(input logic [ID_W-1:0] id,
                                       input logic [ID_W-1:0] parent,
                                       output int unsigned s);
        s = n_tasks;
        if (n_tasks >= MAX_TASKS)
            return 1'b0;
        tab_id[s]     = id;
        tab_parent[s] = parent;
        tab_st[s]     = TS_READY;
        tab_wait[s]   = '0;
        n_tasks++;
        return 1'b1;
    endfunction

    // round-robin scan: frees waiters on finished targets, follows ready targets
    function automatic bit pick_next_task(output int unsigned s);
        int unsigned pos;
        int          t;
        s = 0;
        if (n_tasks == 0)
            return 1'b0;
        pos = cur_valid ? (cur_slot + 1) % n_tasks : 0;
        for (int v = 0; v < 2 * MAX_TASKS; v++)
        begin
            if (tab_st[pos] == TS_READY)
            begin
                cur_slot  = pos;
                cur_valid = 1'b1;
                s = pos;
                return 1'b1;
            end
            if (tab_st[pos] == TS_WAITING && tab_wait[pos] != 0)
            begin
                t = find_task(tab_wait[pos]);
                if (t >= 0 && tab_st[t] == TS_FINISHED)
                begin
                    tab_wait[pos] = '0;
                    tab_st[pos]   = TS_READY;
                end
                else if (t >= 0 && tab_st[t] == TS_READY)
                begin
                    pos = t;
                    continue;
                end
            end
            pos = (pos + 1) % n_tasks;
        end
        return 1'b0;
    endfunction

    function automatic sched_result_t predict_request(input logic [MODE_W-1:0] m,
                                                      input logic [ID_W-1:0] a);
        sched_result_t r;
        int unsigned   s;
        int            t;
        r = '0;
        s = 0;
        case (m)
            MODE_ADD_NEW:
                if (append_task(fresh_id, '0, s))
                begin
                    r = '{1'b1, fresh_id, s[SLOT_W-1:0]};
                    fresh_id++;
                end
            MODE_ADD_ID:
                if (append_task(a, '0, s))
                    r = '{1'b1, a, s[SLOT_W-1:0]};
            MODE_FORK:
                if (cur_valid && append_task(fresh_id, tab_id[cur_slot], s))
                begin
                    r = '{1'b1, fresh_id, s[SLOT_W-1:0]};
                    fresh_id++;
                end
            MODE_EXIT:
                if (cur_valid)
                begin
                    tab_st[cur_slot] = TS_FINISHED;
                    r.ok = 1'b1;
                end
            MODE_WAIT:
                if (cur_valid && a != 0 && a != tab_id[cur_slot])
                begin
                    t = find_task(a);
                    if (t >= 0 && tab_st[t] != TS_FINISHED)
                    begin
                        tab_wait[cur_slot] = a;
                        tab_st[cur_slot]   = TS_WAITING;
                        r.ok = 1'b1;
                    end
                end
            MODE_SCHED:
                if (pick_next_task(s))
                    r = '{1'b1, tab_id[s], s[SLOT_W-1:0]};
            default: ;
        endcase
        return r;
    endfunction

    // one request: optional gap, then hold start until taken
    task automatic issue_request(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] a);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        mode    <= m;
        pid_arg <= a;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(predict_request(m, a));
        n_requests++;
    endtask

    task automatic wait_all_done();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected (ok %0b pid %h slot %0d)",
                         $time, ok, pid_out, slot_out);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                if (want.ok)
                    n_picked++;
                else
                    n_refused++;
                if (ok !== want.ok)
                begin
                    $display("%0t: ok expected %0b got %0b", $time, want.ok, ok);
                    errors++;
                end
                if (pid_out !== want.pid)
                begin
                    $display("%0t: pid_out expected %h got %h", $time, want.pid, pid_out);
                    errors++;
                end
                if (slot_out !== want.slot)
                begin
                    $display("%0t: slot_out expected %0d got %0d",
                             $time, want.slot, slot_out);
                    errors++;
                end
            end
        end
    end

    function automatic logic [ID_W-1:0] some_known_id();
        if (n_tasks == 0)
            return ID_W'($urandom);
        return tab_id[$urandom_range(0, n_tasks - 1)];
    endfunction

    // empty table: every request that needs a task is refused
    task automatic test_empty_table();
        issue_request(MODE_SCHED, '0);
        issue_request(MODE_FORK, '0);
        issue_request(MODE_EXIT, '0);
        issue_request(MODE_WAIT, 16'h0001);
        issue_request(MODE_UNDEF_A, 16'hFFFF);
        issue_request(MODE_UNDEF_B, '0);
        wait_all_done();
    endtask

    // basic lifecycle and the bad-wait cases
    task automatic test_lifecycle();
        issue_request(MODE_ADD_NEW, '0);
        issue_request(MODE_ADD_NEW, '0);
        issue_request(MODE_ADD_ID, 16'hFFFF);
        issue_request(MODE_ADD_ID, 16'h0000);
        issue_request(MODE_ADD_ID, 16'h0001);     // duplicate id
        issue_request(MODE_SCHED, '0);
        issue_request(MODE_FORK, '0);
        issue_request(MODE_WAIT, 16'h0000);       // id zero
        issue_request(MODE_WAIT, tab_id[cur_slot]); // self
        issue_request(MODE_WAIT, 16'h1234);       // unknown
        issue_request(MODE_WAIT, 16'hFFFF);       // good, target ready
        issue_request(MODE_SCHED, '0);            // picks the next ready task
        issue_request(MODE_EXIT, '0);
        issue_request(MODE_SCHED, '0);            // picks the wait target
        issue_request(MODE_WAIT, 16'hFFFF);       // self, target is current
        issue_request(MODE_EXIT, '0);
        issue_request(MODE_SCHED, '0);
        issue_request(MODE_EXIT, '0);
        issue_request(MODE_SCHED, '0);
        issue_request(MODE_UNDEF_A, '0);
        wait_all_done();
    endtask

    task automatic test_random_mix(input int unsigned count, input int unsigned add_pct);
        int unsigned     r;
        logic [ID_W-1:0] a;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i % 60 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < add_pct)
                issue_request(MODE_ADD_NEW, ID_W'($urandom));
            else if (r < add_pct + 2)
            begin
                case ($urandom_range(0, 3))
                    0: a = some_known_id();
                    1: a = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    default: a = ID_W'($urandom);
                endcase
                issue_request(MODE_ADD_ID, a);
            end
            else if (r < add_pct + 5)
                issue_request(MODE_FORK, ID_W'($urandom));
            else if (r < add_pct + 16)
                issue_request(MODE_EXIT, ID_W'($urandom));
            else if (r < add_pct + 38)
            begin
                case ($urandom_range(0, 9))
                    0: a = '0;
                    1: a = ID_W'($urandom);
                    default: a = some_known_id();
                endcase
                issue_request(MODE_WAIT, a);
            end
            else if (r < 98)
                issue_request(MODE_SCHED, ID_W'($urandom));
            else
                issue_request($urandom_range(0, 1) ? MODE_UNDEF_A : MODE_UNDEF_B,
                              ID_W'($urandom));
            if (i % 400 == 399)
                wait_all_done();
        end
        no_idle = 1'b0;
        wait_all_done();
    endtask

    // fill the table, then every add is refused
    task automatic test_full_table();
        while (n_tasks < MAX_TASKS)
            issue_request($urandom_range(0, 1) ? MODE_ADD_NEW : MODE_FORK, ID_W'($urandom));
        issue_request(MODE_ADD_NEW, '0);
        issue_request(MODE_ADD_ID, 16'hABCD);
        issue_request(MODE_FORK, '0);
        issue_request(MODE_SCHED, '0);
        wait_all_done();
        test_random_mix(40, 0);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        mode     = '0;
        pid_arg  = '0;
        n_tasks  = 0;
        cur_slot = 0;
        cur_valid = 1'b0;
        fresh_id = 16'd1;
        errors   = 0;
        n_requests = 0;
        n_checked  = 0;
        n_picked   = 0;
        n_refused  = 0;
        no_idle    = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_lifecycle();
        test_random_mix(1280, 4);
        test_full_table();

        wait_all_done();
        repeat (50) @(posedge clk);
        $display("covered %0d requests, %0d results checked (%0d succeeded, %0d refused)",
                 n_requests, n_checked, n_picked, n_refused);
        $display("table reached %0d tasks, empty, partly filled and full", n_tasks);
        if (errors == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/trrs_pkg.sv
rtl/trrs_ctrl.sv
rtl/trrs_datapath.sv
rtl/task_table_round_robin_scheduler.sv
tb/task_table_round_robin_scheduler_test.sv
